// ----- sv/hdc_pkg.sv -----
`default_nettype none
package hdc_pkg;

  localparam int FEATURE_COUNT = 6;
  localparam int Q_OFFSET = 88;
  localparam int Q_MAX = 176;
  // ceil(2^20 / 12), exact floor for magnitudes up to 2^15
  localparam int RECIP_12 = 87382;
  localparam int RECIP_SHIFT = 20;
  localparam int COUNT_MAX = 4095;

  localparam logic [1:0] REQ_WVEC = 2'd0;
  localparam logic [1:0] REQ_WLAB = 2'd1;
  localparam logic [1:0] REQ_CLASSIFY = 2'd2;

  localparam logic CFG_CLASS_COUNT_X = 1'b0;
  localparam logic CFG_CLASS_COUNT_Z = 1'b1;

  typedef enum logic [1:0] {
    CMD_WVEC = 2'd0,
    CMD_WLAB = 2'd1,
    CMD_CLASSIFY = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic axis;
    logic [6:0] cls;
    logic [6:0] word;
    logic [31:0] data;
    logic [15:0] label;
    logic [FEATURE_COUNT-1:0][7:0] q;
  } cmd_t;

endpackage
`default_nettype wire

// ----- sv/hd_thermometer_hamming_classifier.sv -----
// hyperdimensional classifier, two class libraries (x and z) compared by hamming count
// in channel: in_valid/in_ready carries one item; in_req_type selects a library word
//   write, a label write or a classify of the six features
// out channel: out_valid/out_ready carries one item per classify, with the winning
//   label, count and index of each axis; writes and unused codes give no item
// cfg port: cfg_we writes cfg_data into class_count_x (index 0) or class_count_z (1)
// items pass an input register and a two-entry command queue before the search engine
// a write is done as the engine takes it; a classify runs the engine through the run,
//   drain and label states (run and drain are skipped when both counts are zero), run
//   reading N*VECTOR_WORDS words of each library, N the larger saturated class count;
//   each library memory gives one word a cycle and both axes are searched together
// the input side keeps accepting up to three items while the engine or receiver stalls;
//   a finished result is held until out_ready, and the next classify waits for it
// reset clears the control state and loads class counts 37 and 77; library contents
//   are undefined until written
`default_nettype none
module hd_thermometer_hamming_classifier
  import hdc_pkg::*;
#(
  parameter int MAX_CLASSES = 128,
  parameter int VECTOR_WORDS = 90,
  parameter int SLOT_BITS = 352
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] in_req_type,
  input  wire logic in_axis,
  input  wire logic [6:0] in_class_index,
  input  wire logic [6:0] in_word_index,
  input  wire logic [31:0] in_write_data,
  input  wire logic [15:0] in_label_value,
  input  wire logic [15:0] in_feature_0,
  input  wire logic [15:0] in_feature_1,
  input  wire logic [15:0] in_feature_2,
  input  wire logic [15:0] in_feature_3,
  input  wire logic [15:0] in_feature_4,
  input  wire logic [15:0] in_feature_5,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [15:0] out_predicted_x,
  output logic [15:0] out_predicted_z,
  output logic [11:0] out_best_count_x,
  output logic [11:0] out_best_count_z,
  output logic [6:0] out_best_index_x,
  output logic [6:0] out_best_index_z,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic [FEATURE_COUNT-1:0][15:0] features;
  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_data, pop_data;

  assign features = {in_feature_5, in_feature_4, in_feature_3,
                     in_feature_2, in_feature_1, in_feature_0};

  hdc_front #(
    .MAX_CLASSES(MAX_CLASSES),
    .VECTOR_WORDS(VECTOR_WORDS)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_axis(in_axis),
    .in_class_index(in_class_index),
    .in_word_index(in_word_index),
    .in_write_data(in_write_data),
    .in_label_value(in_label_value),
    .in_features(features),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data(push_data)
  );

  hdc_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data(push_data),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data(pop_data)
  );

  hdc_engine #(
    .MAX_CLASSES(MAX_CLASSES),
    .VECTOR_WORDS(VECTOR_WORDS),
    .SLOT_BITS(SLOT_BITS)
  ) u_engine (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data(pop_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_predicted_x(out_predicted_x),
    .out_predicted_z(out_predicted_z),
    .out_best_count_x(out_best_count_x),
    .out_best_count_z(out_best_count_z),
    .out_best_index_x(out_best_index_x),
    .out_best_index_z(out_best_index_z)
  );

endmodule
`default_nettype wire

// ----- sv/hdc_front.sv -----
`default_nettype none
module hdc_front
  import hdc_pkg::*;
#(
  parameter int MAX_CLASSES = 128,
  parameter int VECTOR_WORDS = 90
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] in_req_type,
  input  wire logic in_axis,
  input  wire logic [6:0] in_class_index,
  input  wire logic [6:0] in_word_index,
  input  wire logic [31:0] in_write_data,
  input  wire logic [15:0] in_label_value,
  input  wire logic [FEATURE_COUNT-1:0][15:0] in_features,
  output logic push_valid,
  input  wire logic push_ready,
  output cmd_t push_data
);

  logic v_r, v_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic keep;
  logic accept;

  always_comb begin
    logic neg;
    logic [16:0] mag;
    logic [33:0] prod;
    logic [11:0] qa;
    logic signed [13:0] sq;
    cmd_nxt.kind = CMD_CLASSIFY;
    cmd_nxt.axis = in_axis;
    cmd_nxt.cls = in_class_index;
    cmd_nxt.word = in_word_index;
    cmd_nxt.data = in_write_data;
    cmd_nxt.label = in_label_value;
    keep = 1'b0;
    unique case (in_req_type)
      REQ_WVEC: begin
        cmd_nxt.kind = CMD_WVEC;
        keep = (32'(in_class_index) < MAX_CLASSES) && (32'(in_word_index) < VECTOR_WORDS);
      end
      REQ_WLAB: begin
        cmd_nxt.kind = CMD_WLAB;
        keep = 32'(in_class_index) < MAX_CLASSES;
      end
      REQ_CLASSIFY: begin
        cmd_nxt.kind = CMD_CLASSIFY;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
    for (int i = 0; i < FEATURE_COUNT; i++) begin
      neg = in_features[i][15];
      mag = neg ? 17'(-{1'b1, in_features[i]}) : {1'b0, in_features[i]};
      prod = 34'(mag) * 34'(RECIP_12);
      qa = 12'(prod >> RECIP_SHIFT);
      sq = neg ? 14'(Q_OFFSET) - 14'(qa) : 14'(Q_OFFSET) + 14'(qa);
      if (sq < 0) begin
        cmd_nxt.q[i] = 8'd0;
      end else if (sq > 14'(Q_MAX)) begin
        cmd_nxt.q[i] = 8'(Q_MAX);
      end else begin
        cmd_nxt.q[i] = 8'(sq);
      end
    end
  end

  assign in_ready = !v_r || push_ready;
  assign accept = in_valid && in_ready;
  assign v_nxt = (v_r && !push_ready) || (accept && keep);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    if (accept && keep) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign push_valid = v_r;
  assign push_data = cmd_r;

endmodule
`default_nettype wire

// ----- sv/hdc_queue.sv -----
`default_nettype none
module hdc_queue
  import hdc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic push_ready,
  input  wire cmd_t push_data,
  output logic pop_valid,
  input  wire logic pop_ready,
  output cmd_t pop_data
);

  cmd_t slots_r [2];
  logic wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid = cnt_r != 2'd0;
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_data = slots_r[rp_r];

  always_comb begin
    wp_nxt = wp_r ^ push;
    rp_nxt = rp_r ^ pop;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slots_r[wp_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- sv/hdc_engine.sv -----
`default_nettype none
module hdc_engine
  import hdc_pkg::*;
#(
  parameter int MAX_CLASSES = 128,
  parameter int VECTOR_WORDS = 90,
  parameter int SLOT_BITS = 352
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic pop_valid,
  output logic pop_ready,
  input  wire cmd_t pop_data,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [15:0] out_predicted_x,
  output logic [15:0] out_predicted_z,
  output logic [11:0] out_best_count_x,
  output logic [11:0] out_best_count_z,
  output logic [6:0] out_best_index_x,
  output logic [6:0] out_best_index_z
);

  localparam int DEPTH = MAX_CLASSES * VECTOR_WORDS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CLS_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int NC_W = $clog2(MAX_CLASSES + 1);
  localparam int WRD_W = $clog2(VECTOR_WORDS);
  localparam int OFF_W = $clog2(SLOT_BITS);
  localparam int SLOT_W = $clog2(VECTOR_WORDS * 32 / SLOT_BITS + 2);
  localparam int CNT_W = $clog2(VECTOR_WORDS * 32 + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_LABEL = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [7:0] cfg_x_r, cfg_z_r;
  logic [NC_W-1:0] nx_r, nz_r, nmax_r, nx_sat, nz_sat;
  logic [FEATURE_COUNT-1:0][7:0] q_r;

  logic [ADDR_W-1:0] addr_r, mem_addr;
  logic [WRD_W-1:0] wrd_r;
  logic [CLS_W-1:0] cls_r;
  logic [OFF_W-1:0] off_r;
  logic [SLOT_W-1:0] slot_r;

  logic [31:0] vec_x [DEPTH];
  logic [31:0] vec_z [DEPTH];
  logic [15:0] lab_x [MAX_CLASSES];
  logic [15:0] lab_z [MAX_CLASSES];
  logic [31:0] rd_x_r, rd_z_r;

  logic [31:0] qw, qw_r;
  logic p_valid_r, p_first_r, p_last_r, p_act_x_r, p_act_z_r;
  logic [CNT_W-1:0] acc_x_r, acc_z_r, sum_x, sum_z;
  logic [CNT_W-1:0] bx_c_r, bz_c_r;
  logic [CLS_W-1:0] bx_i_r, bz_i_r, p_cls_r;

  logic pop_go, is_classify, last_word, last_cls;
  logic out_valid_r;
  logic [15:0] pred_x_r, pred_z_r;

  assign is_classify = pop_data.kind == CMD_CLASSIFY;
  assign pop_ready = (state_r == S_IDLE) && !(is_classify && out_valid_r);
  assign pop_go = pop_valid && pop_ready;
  assign last_word = 32'(wrd_r) == VECTOR_WORDS - 1;
  assign last_cls = 32'(cls_r) == 32'(nmax_r) - 1;

  assign nx_sat = (32'(cfg_x_r) > MAX_CLASSES) ? NC_W'(MAX_CLASSES) : NC_W'(cfg_x_r);
  assign nz_sat = (32'(cfg_z_r) > MAX_CLASSES) ? NC_W'(MAX_CLASSES) : NC_W'(cfg_z_r);

  // query word at the current bit offset; a word spans at most two slots
  always_comb begin
    logic [OFF_W:0] bb;
    logic [OFF_W:0] b;
    logic [SLOT_W-1:0] s;
    for (int j = 0; j < 32; j++) begin
      bb = (OFF_W + 1)'(off_r) + (OFF_W + 1)'(j);
      if (32'(bb) < SLOT_BITS) begin
        s = slot_r;
        b = bb;
      end else begin
        s = slot_r + SLOT_W'(1);
        b = bb - (OFF_W + 1)'(SLOT_BITS);
      end
      qw[j] = (32'(s) < FEATURE_COUNT) && (32'(b) > 32'(q_r[3'(s)]));
    end
  end

  assign mem_addr = (state_r == S_IDLE)
                    ? ADDR_W'(32'(pop_data.cls) * VECTOR_WORDS + 32'(pop_data.word))
                    : addr_r;

  always_ff @(posedge clk) begin
    if (pop_go && pop_data.kind == CMD_WVEC && !pop_data.axis) begin
      vec_x[mem_addr] <= pop_data.data;
    end
    rd_x_r <= vec_x[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (pop_go && pop_data.kind == CMD_WVEC && pop_data.axis) begin
      vec_z[mem_addr] <= pop_data.data;
    end
    rd_z_r <= vec_z[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (pop_go && pop_data.kind == CMD_WLAB) begin
      if (pop_data.axis) begin
        lab_z[CLS_W'(pop_data.cls)] <= pop_data.label;
      end else begin
        lab_x[CLS_W'(pop_data.cls)] <= pop_data.label;
      end
    end
    if (state_r == S_LABEL) begin
      pred_x_r <= lab_x[bx_i_r];
      pred_z_r <= lab_z[bz_i_r];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (pop_go && is_classify) begin
          state_nxt = ((nx_sat > nz_sat ? nx_sat : nz_sat) == '0) ? S_LABEL : S_RUN;
        end
      end
      S_RUN: begin
        if (last_word && last_cls) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_LABEL;
      S_LABEL: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign sum_x = (p_first_r ? '0 : acc_x_r) + CNT_W'($countones(rd_x_r ^ qw_r));
  assign sum_z = (p_first_r ? '0 : acc_z_r) + CNT_W'($countones(rd_z_r ^ qw_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cfg_x_r <= 8'd37;
      cfg_z_r <= 8'd77;
      p_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CLASS_COUNT_X: cfg_x_r <= cfg_data;
          CFG_CLASS_COUNT_Z: cfg_z_r <= cfg_data;
          default: ;
        endcase
      end
      p_valid_r <= state_r == S_RUN;
      if (state_r == S_LABEL) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && pop_go && is_classify) begin
      q_r <= pop_data.q;
      nx_r <= nx_sat;
      nz_r <= nz_sat;
      nmax_r <= nx_sat > nz_sat ? nx_sat : nz_sat;
      addr_r <= '0;
      wrd_r <= '0;
      cls_r <= '0;
      off_r <= '0;
      slot_r <= '0;
      bx_c_r <= '0;
      bz_c_r <= '0;
      bx_i_r <= '0;
      bz_i_r <= '0;
    end else if (state_r == S_RUN) begin
      addr_r <= addr_r + ADDR_W'(1);
      if (last_word) begin
        wrd_r <= '0;
        off_r <= '0;
        slot_r <= '0;
        cls_r <= cls_r + CLS_W'(1);
      end else begin
        wrd_r <= wrd_r + WRD_W'(1);
        if (32'(off_r) + 32 >= SLOT_BITS) begin
          off_r <= OFF_W'(32'(off_r) + 32 - SLOT_BITS);
          slot_r <= slot_r + SLOT_W'(1);
        end else begin
          off_r <= off_r + OFF_W'(32);
        end
      end
    end
    qw_r <= qw;
    p_first_r <= wrd_r == '0;
    p_last_r <= last_word;
    p_cls_r <= cls_r;
    p_act_x_r <= 32'(cls_r) < 32'(nx_r);
    p_act_z_r <= 32'(cls_r) < 32'(nz_r);
    if (p_valid_r) begin
      acc_x_r <= sum_x;
      acc_z_r <= sum_z;
      if (p_last_r && p_act_x_r && sum_x > bx_c_r) begin
        bx_c_r <= sum_x;
        bx_i_r <= p_cls_r;
      end
      if (p_last_r && p_act_z_r && sum_z > bz_c_r) begin
        bz_c_r <= sum_z;
        bz_i_r <= p_cls_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_predicted_x = pred_x_r;
  assign out_predicted_z = pred_z_r;
  assign out_best_count_x = (32'(bx_c_r) > COUNT_MAX) ? 12'(COUNT_MAX) : 12'(bx_c_r);
  assign out_best_count_z = (32'(bz_c_r) > COUNT_MAX) ? 12'(COUNT_MAX) : 12'(bz_c_r);
  assign out_best_index_x = 7'(bx_i_r);
  assign out_best_index_z = 7'(bz_i_r);

`ifndef SYNTHESIS
  a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> 32'(cls_r) < 32'(nmax_r))
    else $error("class counter past class count");
  a_pipe_only_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r |-> (state_r == S_RUN || state_r == S_DRAIN))
    else $error("compare pipe busy outside search");
  a_label_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LABEL |-> !p_valid_r)
    else $error("label read before last compare");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LABEL |->
      (32'(bx_c_r) <= VECTOR_WORDS * 32 && 32'(bz_c_r) <= VECTOR_WORDS * 32))
    else $error("best count above vector length");
  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LABEL |=> out_valid_r)
    else $error("result not presented after search");
`endif

endmodule
`default_nettype wire
